### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bqcr_pkg.sv
// ----------------------------------------------------------------------------
// bqcr_pkg
// Constants and types for the biquad coefficient ramp unit
// ----------------------------------------------------------------------------
package bqcr_pkg;

  // parameter defaults
  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int COEF_FRAC_BITS_DEF = 28;
  localparam int MAX_BLOCK_LOG2_DEF = 12;

  // coefficient formats: Q3.28 target, Q3.36 running value
  localparam int COEF_W     = 32;
  localparam int EXT_BITS   = 8;
  localparam int COEF_EXT_W = COEF_W + EXT_BITS;
  localparam int NUM_COEF   = 5;

  // config port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int LEN_CFG_W  = 4;
  localparam logic [LEN_CFG_W-1:0] BLOCK_LEN_RST = LEN_CFG_W'(6);

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_B0  = 3'd0,
    REG_TARGET_B1  = 3'd1,
    REG_TARGET_B2  = 3'd2,
    REG_TARGET_A1  = 3'd3,
    REG_TARGET_A2  = 3'd4,
    REG_BLOCK_LEN  = 3'd5
  } cfg_reg_t;

  // coefficient slots
  localparam int C_B0 = 0;
  localparam int C_B1 = 1;
  localparam int C_B2 = 2;
  localparam int C_A1 = 3;
  localparam int C_A2 = 4;

  typedef logic signed [COEF_W-1:0]     coef_t;
  typedef logic signed [COEF_EXT_W-1:0] coef_ext_t;

endpackage

### design/biquad_filter_coefficient_ramp_unit.sv
// ----------------------------------------------------------------------------
// biquad_filter_coefficient_ramp_unit
// Direct form I biquad whose five coefficients ramp linearly toward their
// targets over each block of 2^block_len_log2 samples
// ----------------------------------------------------------------------------
//  channel | ports                                   | beat
//  --------+-----------------------------------------+------------------------
//  in      | in_valid, in_stall, in_sample_in,       | one sample, valid & !stall
//          | in_voice_reset                          |
//  out     | out_valid, out_stall, out_sample_out    | one sample, valid & !stall
//  cfg     | cfg_wr_en, cfg_index, cfg_data          | one write per cycle
//
//  One sample per clock sustained while out is not stalled. The input beat
//  loads the input stage and the ramped coefficients; when that stage
//  advances, the five multiplies, sum, rounding and saturation load into
//  the output register, which drives out.
//  The output-history feedback closes within that second stage.
//  Reset: synchronous, active low; coefficients return to b0 = 1.0.
//  A stall on out holds the output register, then the input stage, then in.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module biquad_filter_coefficient_ramp_unit #(
  parameter int SAMPLE_WIDTH   = bqcr_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bqcr_pkg::COEF_FRAC_BITS_DEF,
  parameter int MAX_BLOCK_LOG2 = bqcr_pkg::MAX_BLOCK_LOG2_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample_in,
  input  logic                              in_voice_reset,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]    out_sample_out,
  // config port
  input  logic                              cfg_wr_en,
  input  logic [bqcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bqcr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bqcr_pkg::*;

  localparam int POS_W  = (MAX_BLOCK_LOG2 > 0) ? MAX_BLOCK_LOG2 : 1;
  localparam int LEN_W  = (MAX_BLOCK_LOG2 > 0) ? $clog2(MAX_BLOCK_LOG2 + 1) : 1;
  localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
  localparam int ACC_W  = PROD_W + 3;

  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SMAX = (ACC_W'(1) << (SAMPLE_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

  // configuration registers
  coef_t                 target_r [NUM_COEF];
  logic [LEN_CFG_W-1:0]  block_len_log2_r;

  // ramp state
  coef_ext_t             run_r  [NUM_COEF];
  coef_ext_t             run_nxt[NUM_COEF];
  coef_ext_t             step_r [NUM_COEF];
  coef_ext_t             step_nxt[NUM_COEF];
  logic                  ramp_r, ramp_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;

  // filter history
  logic signed [SAMPLE_WIDTH-1:0] xh1_r, xh2_r, yh1_r, yh2_r;

  // input stage and output register
  logic                           s1_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample_r;
  logic                           s1_vr_r;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;

  logic in_acc, s1_adv;

  // handshake
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        target_r[k] <= '0;
      end
      target_r[C_B0]   <= COEF_W'(1) << COEF_FRAC_BITS;
      block_len_log2_r <= BLOCK_LEN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TARGET_B0: target_r[C_B0] <= cfg_data[COEF_W-1:0];
        REG_TARGET_B1: target_r[C_B1] <= cfg_data[COEF_W-1:0];
        REG_TARGET_B2: target_r[C_B2] <= cfg_data[COEF_W-1:0];
        REG_TARGET_A1: target_r[C_A1] <= cfg_data[COEF_W-1:0];
        REG_TARGET_A2: target_r[C_A2] <= cfg_data[COEF_W-1:0];
        REG_BLOCK_LEN: block_len_log2_r <= cfg_data[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // block length, clamped to the supported maximum
  logic [LEN_W-1:0] len_eff;
  logic [POS_W:0]   blk_len, pos_inc;
  logic             blk_start;

  always_comb begin
    if (int'(block_len_log2_r) > MAX_BLOCK_LOG2) begin
      len_eff = LEN_W'(MAX_BLOCK_LOG2);
    end else begin
      len_eff = LEN_W'(block_len_log2_r);
    end
    blk_len   = (POS_W + 1)'(1) << len_eff;
    pos_inc   = {1'b0, pos_r} + (POS_W + 1)'(1);
    blk_start = (pos_r == '0);
    pos_nxt   = (pos_inc >= blk_len) ? '0 : pos_inc[POS_W-1:0];
  end

  // per-coefficient step, snap and ramp
  coef_ext_t          tgt_ext[NUM_COEF];
  coef_ext_t          base   [NUM_COEF];
  logic signed [COEF_EXT_W:0] diff   [NUM_COEF];
  logic signed [COEF_EXT_W:0] diff_sh[NUM_COEF];

  always_comb begin
    ramp_nxt = in_voice_reset ? 1'b0 : (blk_start || ramp_r);
    for (int k = 0; k < NUM_COEF; k++) begin
      tgt_ext[k]  = {target_r[k], {EXT_BITS{1'b0}}};
      diff[k]     = {tgt_ext[k][COEF_EXT_W-1], tgt_ext[k]} - {run_r[k][COEF_EXT_W-1], run_r[k]};
      diff_sh[k]  = diff[k] >>> len_eff;
      step_nxt[k] = blk_start ? diff_sh[k][COEF_EXT_W-1:0] : step_r[k];
      base[k]     = in_voice_reset ? tgt_ext[k] : run_r[k];
      run_nxt[k]  = ramp_nxt ? (base[k] + step_nxt[k]) : base[k];
    end
  end

  // ramp state advances on each input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        run_r[k]  <= '0;
        step_r[k] <= '0;
      end
      run_r[C_B0] <= COEF_EXT_W'(1) << (COEF_FRAC_BITS + EXT_BITS);
      ramp_r      <= 1'b1;
      pos_r       <= '0;
    end else if (in_acc) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        run_r[k]  <= run_nxt[k];
        step_r[k] <= step_nxt[k];
      end
      ramp_r <= ramp_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_sample_in;
      s1_vr_r     <= in_voice_reset;
    end
  end

  // filter datapath: coefficients in run_r belong to the sample in s1
  coef_t                          cq[NUM_COEF];
  logic signed [SAMPLE_WIDTH-1:0] xh1, xh2, yh1, yh2;
  logic signed [PROD_W-1:0]       p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]        acc, acc_sh;
  logic signed [SAMPLE_WIDTH-1:0] y;

  always_comb begin
    for (int k = 0; k < NUM_COEF; k++) begin
      cq[k] = run_r[k][COEF_EXT_W-1:EXT_BITS];
    end
    // voice reset clears the history ahead of its own sample
    xh1 = s1_vr_r ? '0 : xh1_r;
    xh2 = s1_vr_r ? '0 : xh2_r;
    yh1 = s1_vr_r ? '0 : yh1_r;
    yh2 = s1_vr_r ? '0 : yh2_r;
    p_b0 = s1_sample_r * cq[C_B0];
    p_b1 = xh1 * cq[C_B1];
    p_b2 = xh2 * cq[C_B2];
    p_a1 = yh1 * cq[C_A1];
    p_a2 = yh2 * cq[C_A2];
    acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2) - ACC_W'(p_a1) - ACC_W'(p_a2) + RND;
    acc_sh = acc >>> COEF_FRAC_BITS;
    // saturate to the sample range
    if (acc_sh > SMAX) begin
      y = SMAX[SAMPLE_WIDTH-1:0];
    end else if (acc_sh < SMIN) begin
      y = SMIN[SAMPLE_WIDTH-1:0];
    end else begin
      y = acc_sh[SAMPLE_WIDTH-1:0];
    end
  end

  // history follows each sample leaving the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xh1_r <= '0;
      xh2_r <= '0;
      yh1_r <= '0;
      yh2_r <= '0;
    end else if (s1_adv) begin
      xh1_r <= s1_sample_r;
      xh2_r <= xh1;
      yh1_r <= y;
      yh2_r <= yh1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sample_r <= y;
    end
  end

  // checks
  `ASSERT_SAME(a_stall_full, in_stall, s1_valid_r && out_valid_r && out_stall,
               "input stalled with room in the pipe")
  `ASSERT_NEXT(a_adv_out, s1_adv, out_valid_r, "advanced beat missing from output register")
  `ASSERT_NEXT(a_vr_ramp, in_acc && in_voice_reset, !ramp_r, "ramp still on after voice reset")
  `ASSERT_NEXT(a_vr_snap, in_acc && in_voice_reset,
               (run_r[C_B0] == {$past(target_r[C_B0]), {EXT_BITS{1'b0}}}),
               "b0 not snapped to target on voice reset")

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the biquad coefficient ramp unit. A shadow of the
// filter state (ramping coefficients, history, block position) predicts each
// filtered sample beat; results are checked in order under random idling on
// both channels and register changes between bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import bqcr_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int NUM_SLOTS = 1 << CFG_IDX_W;
  localparam int RANDOM_ITEMS = 2000;
  localparam int STALL_LIMIT = 2000;
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam longint Y_MAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint Y_MIN = -Y_MAX - 1;
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS_DEF;
  localparam logic [COEF_W-1:0] COEF_POS_MAX = 32'h7fff_ffff;
  localparam logic [COEF_W-1:0] COEF_NEG_MAX = 32'h8000_0000;

  // shadow of the filter: ramping coefficients, history and expected samples
  class biquad_ramp_tracker;
    logic signed [COEF_W-1:0]     target [NUM_COEF];
    logic [LEN_CFG_W-1:0]         len_log2;
    logic signed [COEF_EXT_W-1:0] coef [NUM_COEF];
    logic signed [COEF_EXT_W-1:0] step [NUM_COEF];
    logic signed [SW-1:0]         x_hist [2];
    logic signed [SW-1:0]         y_hist [2];
    int unsigned                  position;
    bit                           ramping;
    logic signed [SW-1:0]         due [$];
    int                           errors;
    int                           matched;

    function new();
      for (int k = 0; k < NUM_COEF; k++) begin
        target[k] = '0;
        coef[k] = '0;
        step[k] = '0;
      end
      target[C_B0] = COEF_ONE;
      coef[C_B0] = COEF_EXT_W'(longint'(1) <<< (COEF_FRAC_BITS_DEF + EXT_BITS));
      len_log2 = BLOCK_LEN_RST;
      x_hist[0] = '0;
      x_hist[1] = '0;
      y_hist[0] = '0;
      y_hist[1] = '0;
      position = 0;
      ramping = 1'b1;
      errors = 0;
      matched = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TARGET_B0: target[C_B0] = data;
        REG_TARGET_B1: target[C_B1] = data;
        REG_TARGET_B2: target[C_B2] = data;
        REG_TARGET_A1: target[C_A1] = data;
        REG_TARGET_A2: target[C_A2] = data;
        REG_BLOCK_LEN: len_log2 = data[LEN_CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic signed [SW-1:0] x, logic clr);
      int unsigned lg;
      longint diff;
      longint acc;
      longint y;
      longint c [NUM_COEF];
      lg = (len_log2 > MAX_BLOCK_LOG2_DEF) ? MAX_BLOCK_LOG2_DEF : len_log2;
      // block start: fresh per-sample steps toward the targets
      if (position == 0) begin
        for (int k = 0; k < NUM_COEF; k++) begin
          diff = (longint'(target[k]) <<< EXT_BITS) - longint'(coef[k]);
          step[k] = COEF_EXT_W'(diff >>> lg);
        end
        ramping = 1'b1;
      end
      // voice reset: clear history, snap to targets, no ramp for this block
      if (clr) begin
        x_hist[0] = '0;
        x_hist[1] = '0;
        y_hist[0] = '0;
        y_hist[1] = '0;
        for (int k = 0; k < NUM_COEF; k++)
          coef[k] = COEF_EXT_W'(longint'(target[k]) <<< EXT_BITS);
        ramping = 1'b0;
      end
      if (ramping) begin
        for (int k = 0; k < NUM_COEF; k++)
          coef[k] = coef[k] + step[k];
      end
      for (int k = 0; k < NUM_COEF; k++)
        c[k] = longint'(coef[k] >>> EXT_BITS);
      // five taps, round half up, saturate
      acc = longint'(x) * c[C_B0] + longint'(x_hist[0]) * c[C_B1]
          + longint'(x_hist[1]) * c[C_B2] - longint'(y_hist[0]) * c[C_A1]
          - longint'(y_hist[1]) * c[C_A2] + (longint'(1) <<< (COEF_FRAC_BITS_DEF - 1));
      y = acc >>> COEF_FRAC_BITS_DEF;
      if (y > Y_MAX) y = Y_MAX;
      if (y < Y_MIN) y = Y_MIN;
      x_hist[1] = x_hist[0];
      x_hist[0] = x;
      y_hist[1] = y_hist[0];
      y_hist[0] = SW'(y);
      position++;
      if (position >= (32'd1 << lg)) position = 0;
      due.push_back(SW'(y));
    endfunction

    function void check_sample(logic signed [SW-1:0] got);
      logic signed [SW-1:0] want;
      if (due.size() == 0) begin
        $display("%0t: sample_out beat with nothing expected, got %0d", $time, got);
        errors++;
      end else begin
        want = due.pop_front();
        if (got !== want) begin
          $display("%0t: sample_out mismatch, expected %0d, got %0d", $time, want, got);
          errors++;
        end else begin
          matched++;
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [SW-1:0]  in_sample_in = '0;
  logic                  in_voice_reset = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [SW-1:0]  out_sample_out;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [CFG_DATA_W-1:0] pending_cfg [NUM_SLOTS];
  biquad_ramp_tracker    ramp_track = new();
  bit                    calm = 1'b0;
  int                    n_samples = 0;
  int                    n_resets = 0;
  int                    n_writes = 0;

  biquad_filter_coefficient_ramp_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .in_voice_reset (in_voice_reset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 17);
  end

  // beat monitor: results checked first, then accepted samples predicted
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      ramp_track.check_sample(out_sample_out);
    if (rst_n && in_valid && !in_stall)
      ramp_track.take_sample(in_sample_in, in_voice_reset);
  end

  // watchdog on cycles without any beat
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n)
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  task automatic send_sample(input logic signed [SW-1:0] x, input logic vr);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= x;
    in_voice_reset <= vr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_samples++;
    if (vr) n_resets++;
  endtask

  // hold the sender until every expected sample has come out
  task automatic settle_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ramp_track.due.size() != 0) @(posedge clk);
  endtask

  // write the selected slots of pending_cfg, one per clock
  task automatic program_regs(input logic [NUM_SLOTS-1:0] sel);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sel[i]) begin
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IDX_W'(i);
        cfg_data <= pending_cfg[i];
        @(posedge clk);
        ramp_track.write_reg(CFG_IDX_W'(i), pending_cfg[i]);
        n_writes++;
      end
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_coef();
    case ($urandom_range(9))
      0: return COEF_POS_MAX;
      1: return COEF_NEG_MAX;
      2, 3: return $urandom();
      default: return CFG_DATA_W'($urandom_range(0, 32'h2000_0000)) - COEF_ONE;
    endcase
  endfunction

  // mostly short blocks, upper data bits random
  function automatic logic [CFG_DATA_W-1:0] pick_len_word();
    logic [LEN_CFG_W-1:0] len;
    len = ($urandom_range(3) == 0) ? LEN_CFG_W'($urandom_range(6, 15))
                                   : LEN_CFG_W'($urandom_range(0, 5));
    return ($urandom() & ~CFG_DATA_W'((1 << LEN_CFG_W) - 1)) | CFG_DATA_W'(len);
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(9))
      0: return S_MAX;
      1: return S_MIN;
      2: return SW'($urandom_range(0, 512)) - SW'(256);
      default: return SW'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    int rand_sent;
    int phase;
    int burst;
    rand_sent = 0;
    phase = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: unity b0, samples pass straight through
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample(-SW'(1), 1'b0);
    send_sample(SW'(12345), 1'b1);
    send_sample(SW'(1), 1'b0);

    // extreme targets, one-sample blocks, junk to the unmapped slots
    settle_outputs();
    pending_cfg[REG_TARGET_B0] = COEF_POS_MAX;
    pending_cfg[REG_TARGET_B1] = COEF_NEG_MAX;
    pending_cfg[REG_TARGET_B2] = COEF_POS_MAX;
    pending_cfg[REG_TARGET_A1] = COEF_NEG_MAX;
    pending_cfg[REG_TARGET_A2] = COEF_POS_MAX;
    pending_cfg[REG_BLOCK_LEN] = '0;
    for (int i = REG_BLOCK_LEN + 1; i < NUM_SLOTS; i++) pending_cfg[i] = '1;
    program_regs('1);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b1);
    send_sample(S_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample(S_MAX, 1'b0);

    // most negative b0 and a2, block length code above the maximum
    settle_outputs();
    pending_cfg[REG_TARGET_B0] = COEF_NEG_MAX;
    pending_cfg[REG_TARGET_B1] = '0;
    pending_cfg[REG_TARGET_B2] = '0;
    pending_cfg[REG_TARGET_A1] = '0;
    pending_cfg[REG_TARGET_A2] = COEF_NEG_MAX;
    pending_cfg[REG_BLOCK_LEN] = '1;
    program_regs('1);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(SW'(1), 1'b1);
    send_sample(S_MAX, 1'b0);

    // 16-sample block, then shortened to 2 mid-block
    settle_outputs();
    pending_cfg[REG_TARGET_B0] = COEF_ONE;
    pending_cfg[REG_TARGET_A1] = COEF_NEG_MAX >> 2;
    pending_cfg[REG_TARGET_A2] = COEF_ONE >> 1;
    pending_cfg[REG_BLOCK_LEN] = CFG_DATA_W'(4);
    program_regs('1);
    repeat (5) send_sample(pick_sample(), 1'b0);
    settle_outputs();
    pending_cfg[REG_BLOCK_LEN] = CFG_DATA_W'(1);
    program_regs(NUM_SLOTS'(1) << REG_BLOCK_LEN);
    repeat (3) send_sample(pick_sample(), 1'b0);

    // random bursts with new settings between them
    while (rand_sent < RANDOM_ITEMS) begin
      settle_outputs();
      for (int i = 0; i < NUM_SLOTS; i++)
        pending_cfg[i] = (i == REG_BLOCK_LEN) ? pick_len_word() : pick_coef();
      program_regs((phase == 0) ? '1 : NUM_SLOTS'($urandom_range(0, 255)));
      calm = (phase == 3);
      burst = calm ? 300 : $urandom_range(20, 150);
      repeat (burst) begin
        send_sample(pick_sample(), $urandom_range(99) < 3);
        rand_sent++;
      end
      calm = 1'b0;
      phase++;
    end

    settle_outputs();
    repeat (8) @(posedge clk);
    if (ramp_track.due.size() != 0) begin
      $display("%0t: %0d expected samples never came out", $time, ramp_track.due.size());
      ramp_track.errors++;
    end
    $display("run: %0d samples (%0d voice resets) over %0d setting phases, %0d register writes",
             n_samples, n_resets, phase + 5, n_writes);
    $display("run: %0d filtered samples matched, %0d mismatches", ramp_track.matched,
             ramp_track.errors);
    if (ramp_track.errors == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/bqcr_pkg.sv
design/biquad_filter_coefficient_ramp_unit.sv
tb/tb_top.sv
